FILE: rtl/lms_pkg.sv
// ---------------------------------------------------------------------------
// lms_pkg
// Shared types and codes of the launcher mode sequencer.
// ---------------------------------------------------------------------------
package lms_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 8;
	localparam int CFG_W = 16;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_MAX_HEAT    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_HEAT_MARGIN = 2'd1;
	localparam logic [CIDX_W-1:0] REG_INIT_TMO    = 2'd2;

	localparam logic [9:0]  MAX_HEAT_RST    = 10'd320;
	localparam logic [9:0]  HEAT_MARGIN_RST = 10'd30;
	localparam logic [15:0] INIT_TMO_RST    = 16'd5000;

	localparam logic signed [10:0] STICK_THR = 11'sd100;

	localparam logic [1:0] SW_UP   = 2'd0;
	localparam logic [1:0] SW_MID  = 2'd1;
	localparam logic [1:0] SW_DOWN = 2'd2;

	localparam logic [1:0] CM_STOP   = 2'd0;
	localparam logic [1:0] CM_AUTO   = 2'd1;
	localparam logic [1:0] CM_REMOTE = 2'd2;
	localparam logic [1:0] CM_INIT   = 2'd3;

	localparam logic [1:0] FM_STOP  = 2'd0;
	localparam logic [1:0] FM_READY = 2'd1;
	localparam logic [1:0] FM_FIRE  = 2'd2;
	localparam logic [1:0] FM_HOME  = 2'd3;

	typedef struct packed {
		logic              remote_lost;
		logic              gimbal_stop;
		logic              home_pressed;
		logic [9:0]        heat_b;
		logic [9:0]        heat_a;
		logic              vision_attack;
		logic signed [10:0] fire_stick;
		logic [1:0]        mode_switch;
		logic [1:0]        ctrl_switch;
	} item_t;

	typedef struct packed {
		logic       homed;
		logic       vision_enable;
		logic       pid_clear;
		logic       feeder_run;
		logic       wheels_run;
		logic [1:0] fire_mode;
	} result_t;

	// control mode after this tick's update, homed flag before homing output
	typedef struct packed {
		logic [1:0] cm;
		logic       homed;
	} mode_t;

	typedef struct packed {
		logic [9:0] max_heat;
		logic [9:0] heat_margin;
	} heat_cfg_t;

endpackage

FILE: rtl/lms_mode.sv
// ---------------------------------------------------------------------------
// lms_mode
// Control mode state: homing timer, homed flag and control mode update.
// ---------------------------------------------------------------------------
module lms_mode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          ctrl_switch,
	input  logic                gimbal_stop,
	input  logic                home_pressed,
	input  logic [15:0]         init_tmo,
	input  logic                set_homed,
	output lms_pkg::mode_t      mode
);

	logic [1:0]  cm_q;
	logic [1:0]  prev_cm_q;
	logic        homed_q;
	logic [15:0] timer_q;

	logic [1:0]  decided;
	logic [1:0]  cm_d;
	logic [1:0]  prev_cm_d;
	logic        homed_d;
	logic [15:0] timer_d;
	logic        redecide;

	always_comb begin
		case (ctrl_switch)
			lms_pkg::SW_UP:  decided = lms_pkg::CM_AUTO;
			lms_pkg::SW_MID: decided = lms_pkg::CM_REMOTE;
			default:         decided = lms_pkg::CM_STOP;
		endcase
		if (gimbal_stop)
			decided = lms_pkg::CM_STOP;
		if (decided != lms_pkg::CM_STOP && prev_cm_q == lms_pkg::CM_STOP)
			decided = lms_pkg::CM_INIT;
	end

	always_comb begin
		timer_d  = timer_q;
		homed_d  = homed_q;
		redecide = 1'b1;
		if (cm_q == lms_pkg::CM_INIT) begin
			if (ctrl_switch == lms_pkg::SW_DOWN) begin
				timer_d = '0;
			end else if (!homed_q) begin
				if (timer_q >= init_tmo) begin
					timer_d = '0;
				end else if (home_pressed) begin
					homed_d = 1'b1;
					timer_d = '0;
				end else begin
					timer_d  = timer_q + 16'd1;
					redecide = 1'b0;
				end
			end else begin
				timer_d = '0;
			end
		end
		cm_d      = redecide ? decided : cm_q;
		prev_cm_d = redecide ? decided : prev_cm_q;
	end

	assign mode.cm    = cm_d;
	assign mode.homed = homed_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q      <= lms_pkg::CM_STOP;
			prev_cm_q <= lms_pkg::CM_STOP;
			homed_q   <= 1'b0;
			timer_q   <= '0;
		end else if (step) begin
			cm_q      <= cm_d;
			prev_cm_q <= prev_cm_d;
			homed_q   <= homed_d | set_homed;
			timer_q   <= timer_d;
		end
	end

endmodule

FILE: rtl/lms_fire.sv
// ---------------------------------------------------------------------------
// lms_fire
// Firing mode pick, heat limit, motor flags and change detect.
// ---------------------------------------------------------------------------
module lms_fire (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  lms_pkg::item_t       item,
	input  lms_pkg::mode_t       mode,
	input  lms_pkg::heat_cfg_t   cfg,
	output logic                 set_homed,
	output lms_pkg::result_t     res
);

	logic [1:0]         fm_q;
	logic [1:0]         fm;
	logic signed [11:0] room_a;
	logic signed [11:0] room_b;
	logic signed [11:0] margin;
	logic               heat_ok;
	logic               stick_hit;

	assign room_a  = $signed({2'b00, cfg.max_heat}) - $signed({2'b00, item.heat_a});
	assign room_b  = $signed({2'b00, cfg.max_heat}) - $signed({2'b00, item.heat_b});
	assign margin  = $signed({2'b00, cfg.heat_margin});
	assign heat_ok = (room_a >= margin) && (room_b >= margin);

	assign stick_hit = (item.fire_stick >= lms_pkg::STICK_THR) ||
	                   (item.fire_stick <= -lms_pkg::STICK_THR);

	always_comb begin
		if (heat_ok) begin
			case (mode.cm)
				lms_pkg::CM_AUTO:
					fm = item.vision_attack ? lms_pkg::FM_FIRE : lms_pkg::FM_READY;
				lms_pkg::CM_REMOTE: begin
					if (item.mode_switch == lms_pkg::SW_UP)
						fm = stick_hit ? lms_pkg::FM_FIRE : lms_pkg::FM_READY;
					else
						fm = lms_pkg::FM_STOP;
				end
				lms_pkg::CM_INIT: fm = lms_pkg::FM_HOME;
				default:          fm = lms_pkg::FM_STOP;
			endcase
		end else begin
			fm = (mode.cm == lms_pkg::CM_AUTO) ? lms_pkg::FM_READY : lms_pkg::FM_STOP;
		end
	end

	always_comb begin
		res.fire_mode     = fm;
		res.pid_clear     = (fm != fm_q);
		res.wheels_run    = (fm == lms_pkg::FM_FIRE) || (fm == lms_pkg::FM_READY);
		res.feeder_run    = (fm == lms_pkg::FM_FIRE) ||
		                    (fm == lms_pkg::FM_HOME && !mode.homed && !item.home_pressed);
		set_homed         = (fm == lms_pkg::FM_HOME) && !mode.homed && item.home_pressed;
		res.homed         = mode.homed | set_homed;
		res.vision_enable = !((fm == lms_pkg::FM_HOME) || (mode.cm == lms_pkg::CM_INIT) ||
		                      item.remote_lost);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fm_q <= lms_pkg::FM_STOP;
		else if (step)
			fm_q <= fm;
	end

endmodule

FILE: rtl/launcher_mode_sequencer_top.sv
// ---------------------------------------------------------------------------
// launcher_mode_sequencer_top
// Per-tick firing mode sequencer of a two-barrel launcher.
// ---------------------------------------------------------------------------
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | s_axis_tdata[39:0], one tick item
// m_axis   | out | m_axis_tvalid/tready   | m_axis_tdata[7:0], one result item
// cfg      | in  | cfg_we (no wait)       | cfg_index[1:0], cfg_data[15:0]
//
// One item per clock while the result is not stalled; input register, then
// decision logic into the result register.
// Reset clears mode state, the homing timer and loads register defaults.
// A stalled result holds the result register; the input register still
// takes an item while it is empty or the result register is empty or draining.
// ---------------------------------------------------------------------------
module launcher_mode_sequencer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// ctrl_switch, mode_switch, fire_stick, vision_attack, heat_a, heat_b,
	// home_pressed, gimbal_stop, remote_lost, pad
	input  logic [lms_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// fire_mode, wheels_run, feeder_run, pid_clear, vision_enable, homed, pad
	output logic [lms_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [lms_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [lms_pkg::CFG_W-1:0]    cfg_data
);

	logic                 valid_s1;
	lms_pkg::item_t       item_s1;
	logic                 out_valid_q;
	lms_pkg::result_t     res_q;

	lms_pkg::heat_cfg_t   heat_cfg_q;
	logic [15:0]          init_tmo_q;

	logic                 out_free;
	logic                 step;
	logic                 set_homed;
	lms_pkg::mode_t       mode;
	lms_pkg::result_t     res;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_cfg_q.max_heat    <= lms_pkg::MAX_HEAT_RST;
			heat_cfg_q.heat_margin <= lms_pkg::HEAT_MARGIN_RST;
			init_tmo_q             <= lms_pkg::INIT_TMO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lms_pkg::REG_MAX_HEAT:    heat_cfg_q.max_heat    <= cfg_data[9:0];
				lms_pkg::REG_HEAT_MARGIN: heat_cfg_q.heat_margin <= cfg_data[9:0];
				lms_pkg::REG_INIT_TMO:    init_tmo_q             <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= lms_pkg::item_t'(s_axis_tdata[lms_pkg::IN_W-2:0]);
		if (step)
			res_q <= res;
	end

	lms_mode u_mode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.ctrl_switch  (item_s1.ctrl_switch),
		.gimbal_stop  (item_s1.gimbal_stop),
		.home_pressed (item_s1.home_pressed),
		.init_tmo     (init_tmo_q),
		.set_homed    (set_homed),
		.mode         (mode)
	);

	lms_fire u_fire (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.mode      (mode),
		.cfg       (heat_cfg_q),
		.set_homed (set_homed),
		.res       (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};

endmodule

FILE: rtl/lms_checker.sv
// ---------------------------------------------------------------------------
// lms_checker
// Port-level checks of the launcher mode sequencer, bound to the top level.
// ---------------------------------------------------------------------------
module lms_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [lms_pkg::OUT_W-1:0]  m_axis_tdata
);

	logic [1:0] fm;
	logic       wheels;
	logic       feeder;
	logic       venable;

	assign fm      = m_axis_tdata[1:0];
	assign wheels  = m_axis_tdata[2];
	assign feeder  = m_axis_tdata[3];
	assign venable = m_axis_tdata[5];

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fm == lms_pkg::FM_STOP |-> !wheels && !feeder)
		else $error("motors run in stop mode");

	a_home_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fm == lms_pkg::FM_HOME |-> !wheels && !venable)
		else $error("wheels or vision active while homing");

	a_fire_wheels: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (fm == lms_pkg::FM_FIRE || fm == lms_pkg::FM_READY) |-> wheels)
		else $error("wheels stopped in ready or fire");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind launcher_mode_sequencer_top lms_checker u_lms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
